// ===== hw/rtl/pstq_pkg.sv =====
package pstq_pkg;

	// field widths of the command and result words
	localparam int MODE_W   = 3;
	localparam int ID_W     = 8;
	localparam int DUR_W    = 32;
	localparam int NOW_W    = 48;
	localparam int STATUS_W = 2;

	// most timers reported by one tick
	localparam int RESULT_CAP = 16;
	localparam int KW         = $clog2(RESULT_CAP + 1);

	localparam logic [MODE_W-1:0] MODE_ARM    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_STOP   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_START  = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

endpackage

// ===== hw/rtl/pstq_if.sv =====
interface pstq_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [pstq_pkg::MODE_W-1:0]  mode;
	logic [pstq_pkg::ID_W-1:0]    timer_id;
	logic [pstq_pkg::DUR_W-1:0]   duration;
	logic [pstq_pkg::NOW_W-1:0]   now;

	modport source (output valid, mode, timer_id, duration, now, input ready);
	modport sink   (input valid, mode, timer_id, duration, now, output ready);
endinterface

interface pstq_res_if;
	logic                          valid;
	logic                          ready;
	logic                          fired;
	logic [pstq_pkg::ID_W-1:0]     fired_id;
	logic [pstq_pkg::STATUS_W-1:0] status;
	logic                          pending;
	logic [pstq_pkg::NOW_W-1:0]    next_deadline;
	logic                          paused;
	logic                          last;

	modport source (output valid, fired, fired_id, status, pending, next_deadline, paused, last,
		input ready);
	modport sink   (input valid, fired, fired_id, status, pending, next_deadline, paused, last,
		output ready);
endinterface

// ===== hw/rtl/pstq_addsub.sv =====
module pstq_addsub #(
	parameter int W = 48
) (
	input  pstq_pkg::alu_op_t op,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	output logic [W-1:0]      sum,
	output logic              carry
);

	logic [W:0] b_eff;
	logic [W:0] full;

	// subtract as a + ~b + 1, carry out set means a >= b
	assign b_eff = (op == pstq_pkg::ALU_SUB) ? {1'b0, ~b} : {1'b0, b};
	assign full  = {1'b0, a} + b_eff + {{W{1'b0}}, (op == pstq_pkg::ALU_SUB)};
	assign sum   = full[W-1:0];
	assign carry = full[W];

endmodule

// ===== hw/rtl/pstq_store.sv =====
module pstq_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int TW    = 48
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [pstq_pkg::ID_W-1:0]     wid,
	input  logic [TW-1:0]                 wdl,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [pstq_pkg::ID_W-1:0]     rid_q,
	output logic [TW-1:0]                 rdl_q
);

	logic [pstq_pkg::ID_W-1:0] id_mem [DEPTH];
	logic [TW-1:0]             dl_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			id_mem[waddr] <= wid;
			dl_mem[waddr] <= wdl;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rid_q <= id_mem[raddr];
			rdl_q <= dl_mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/pausable_sorted_timer_queue.sv =====
// Pausable sorted timer queue: holds up to MAX_TIMERS armed timers as (id, deadline) pairs in a
// circular store with one read and one write port, kept sorted by deadline, equal deadlines in
// arrival order. One command word is taken at a time (cmd.ready is high only between commands)
// and gives one result word, or for a tick one word per expired timer (at most 16), every word
// carrying the pending flag, head deadline and paused flag as they stand after the whole
// command. Stop, start, unused modes and a tick while paused do not touch the store; cancel
// does an id search, then a left shift over the tail; arm does an id search and removal, then
// an insertion walk from the tail; a tick scans for expired timers, then reads back and
// reports each one. With registered read data, each entry visited takes a read state and a
// decision state, and the single adder forms local time, deadlines and every deadline compare.
// Popping is a head pointer move, not a shift. Local time is the stop time while paused, else
// now minus the accumulated pause offset, modulo 2^TIME_BITS; deadlines wrap and compare as
// plain unsigned numbers. A result may wait in the output register while the next command is
// taken.
module pausable_sorted_timer_queue #(
	parameter int MAX_TIMERS = 16,
	parameter int TIME_BITS  = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	pstq_cmd_if.sink    cmd,
	pstq_res_if.source  res
);

	localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CW = $clog2(MAX_TIMERS + 1);
	localparam int TW = TIME_BITS;
	localparam int NW = pstq_pkg::NOW_W;
	localparam int KW = pstq_pkg::KW;

	typedef enum logic [16:0] {
		S_IDLE    = 17'b00000000000000001,
		S_LT      = 17'b00000000000000010,
		S_DL      = 17'b00000000000000100,
		S_FIND_RD = 17'b00000000000001000,
		S_FIND_CK = 17'b00000000000010000,
		S_RM_RD   = 17'b00000000000100000,
		S_RM_WR   = 17'b00000000001000000,
		S_DECIDE  = 17'b00000000010000000,
		S_INS_RD  = 17'b00000000100000000,
		S_INS_CK  = 17'b00000001000000000,
		S_SCAN_RD = 17'b00000010000000000,
		S_SCAN_CK = 17'b00000100000000000,
		S_HEAD_RD = 17'b00001000000000000,
		S_HEAD_WT = 17'b00010000000000000,
		S_EM_ONE  = 17'b00100000000000000,
		S_EM_RD   = 17'b01000000000000000,
		S_EM_LD   = 17'b10000000000000000
	} state_t;

	state_t state_q;

	// queue and clock state
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  count_q;
	logic           paused_q;
	logic [TW-1:0]  pause_time_q;
	logic [TW-1:0]  pause_offset_q;
	logic [TW-1:0]  head_dl_q;

	// current command and walk state
	logic [pstq_pkg::MODE_W-1:0]   mode_q;
	logic [pstq_pkg::ID_W-1:0]     id_q;
	logic [TW-1:0]                 dur_q;
	logic [TW-1:0]                 now_q;
	logic [TW-1:0]                 key_q;
	logic [CW-1:0]                 idx_q;
	logic                          found_q;
	logic [pstq_pkg::STATUS_W-1:0] status_q;
	logic [KW-1:0]                 nfire_q;
	logic [KW-1:0]                 k_q;
	logic [AW-1:0]                 base_q;

	// output register
	logic                          out_valid_q;
	logic                          out_fired_q;
	logic [pstq_pkg::ID_W-1:0]     out_id_q;
	logic [pstq_pkg::STATUS_W-1:0] out_status_q;
	logic                          out_pending_q;
	logic [NW-1:0]                 out_nd_q;
	logic                          out_paused_q;
	logic                          out_last_q;

	// shared adder
	pstq_pkg::alu_op_t alu_op;
	logic [TW-1:0]     alu_a;
	logic [TW-1:0]     alu_b;
	logic [TW-1:0]     alu_sum;
	logic              alu_carry;

	// store ports
	logic                      st_we;
	logic [AW-1:0]             st_waddr;
	logic [pstq_pkg::ID_W-1:0] st_wid;
	logic [TW-1:0]             st_wdl;
	logic                      st_re;
	logic [AW-1:0]             st_raddr;
	logic [pstq_pkg::ID_W-1:0] st_rid;
	logic [TW-1:0]             st_rdl;

	logic cmd_fire;
	logic slot_free;
	logic scan_stop;
	logic rm_done;
	logic em_last;

	// physical slot of the entry at a given distance from a base slot
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(MAX_TIMERS))
			s = s - (CW+1)'(MAX_TIMERS);
		return s[AW-1:0];
	endfunction

	pstq_addsub #(
		.W(TW)
	) u_addsub (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	pstq_store #(
		.DEPTH(MAX_TIMERS),
		.AW   (AW),
		.TW   (TW)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wid   (st_wid),
		.wdl   (st_wdl),
		.re    (st_re),
		.raddr (st_raddr),
		.rid_q (st_rid),
		.rdl_q (st_rdl)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign slot_free = !out_valid_q || res.ready;
	assign scan_stop = (nfire_q == KW'(pstq_pkg::RESULT_CAP)) || (idx_q == count_q);
	assign rm_done   = (CW'(idx_q + 1'b1) == count_q);
	assign em_last   = (KW'(k_q + 1'b1) == nfire_q);

	// adder operands: local time, deadline, or key >= stored deadline
	always_comb begin
		alu_op = pstq_pkg::ALU_SUB;
		alu_a  = key_q;
		alu_b  = st_rdl;
		unique case (state_q)
			S_LT: begin
				alu_a = now_q;
				alu_b = (mode_q == pstq_pkg::MODE_START) ? pause_time_q : pause_offset_q;
			end
			S_DL: begin
				alu_op = pstq_pkg::ALU_ADD;
				alu_a  = dur_q;
				alu_b  = key_q;
			end
			default: begin
				alu_op = pstq_pkg::ALU_SUB;
			end
		endcase
	end

	// store accesses
	always_comb begin
		st_we    = 1'b0;
		st_waddr = slot(head_q, idx_q);
		st_wid   = st_rid;
		st_wdl   = st_rdl;
		st_re    = 1'b0;
		st_raddr = slot(head_q, idx_q);
		unique case (state_q)
			S_FIND_RD: st_re = (idx_q != count_q);
			S_SCAN_RD: st_re = !scan_stop;
			S_RM_RD: begin
				st_re    = !rm_done;
				st_raddr = slot(head_q, CW'(idx_q + 1'b1));
			end
			S_RM_WR: st_we = 1'b1;
			S_INS_RD: begin
				if (idx_q == '0) begin
					st_we  = 1'b1;
					st_wid = id_q;
					st_wdl = key_q;
				end else begin
					st_re    = 1'b1;
					st_raddr = slot(head_q, CW'(idx_q - 1'b1));
				end
			end
			S_INS_CK: begin
				// new timer goes after every entry with deadline not above it
				st_we = 1'b1;
				if (alu_carry) begin
					st_wid = id_q;
					st_wdl = key_q;
				end
			end
			S_HEAD_RD: begin
				st_re    = 1'b1;
				st_raddr = head_q;
			end
			S_EM_RD: begin
				st_re    = 1'b1;
				st_raddr = slot(base_q, CW'(k_q));
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			head_q         <= '0;
			count_q        <= '0;
			paused_q       <= 1'b0;
			pause_time_q   <= '0;
			pause_offset_q <= '0;
			idx_q          <= '0;
			nfire_q        <= '0;
			k_q            <= '0;
			found_q        <= 1'b0;
			status_q       <= pstq_pkg::STATUS_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						idx_q    <= '0;
						nfire_q  <= '0;
						k_q      <= '0;
						found_q  <= 1'b0;
						status_q <= pstq_pkg::STATUS_OK;
						state_q  <= S_LT;
					end
				end
				S_LT: begin
					unique case (mode_q)
						pstq_pkg::MODE_ARM:    state_q <= S_DL;
						pstq_pkg::MODE_CANCEL: state_q <= S_FIND_RD;
						pstq_pkg::MODE_TICK:   state_q <= paused_q ? S_EM_ONE : S_SCAN_RD;
						pstq_pkg::MODE_STOP: begin
							if (!paused_q) begin
								pause_time_q <= alu_sum;
								paused_q     <= 1'b1;
							end
							state_q <= S_EM_ONE;
						end
						pstq_pkg::MODE_START: begin
							// start is keyed on the paused flag alone
							if (paused_q) begin
								pause_offset_q <= alu_sum;
								paused_q       <= 1'b0;
							end
							state_q <= S_EM_ONE;
						end
						default: state_q <= S_EM_ONE;
					endcase
				end
				S_DL: state_q <= S_FIND_RD;
				S_FIND_RD: state_q <= (idx_q == count_q) ? S_DECIDE : S_FIND_CK;
				S_FIND_CK: begin
					if (st_rid == id_q) begin
						found_q <= 1'b1;
						state_q <= S_RM_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_FIND_RD;
					end
				end
				S_RM_RD: begin
					if (rm_done) begin
						count_q <= count_q - 1'b1;
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_RM_WR;
					end
				end
				S_RM_WR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_RM_RD;
				end
				S_DECIDE: begin
					if (mode_q == pstq_pkg::MODE_CANCEL) begin
						if (!found_q)
							status_q <= pstq_pkg::STATUS_NOT_FOUND;
						state_q <= S_HEAD_RD;
					end else if (count_q == CW'(MAX_TIMERS)) begin
						status_q <= pstq_pkg::STATUS_FULL;
						state_q  <= S_HEAD_RD;
					end else begin
						idx_q   <= count_q;
						state_q <= S_INS_RD;
					end
				end
				S_INS_RD: begin
					if (idx_q == '0) begin
						count_q <= count_q + 1'b1;
						state_q <= S_HEAD_RD;
					end else begin
						state_q <= S_INS_CK;
					end
				end
				S_INS_CK: begin
					if (alu_carry) begin
						count_q <= count_q + 1'b1;
						state_q <= S_HEAD_RD;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_INS_RD;
					end
				end
				S_SCAN_RD: begin
					if (scan_stop) begin
						// pop the expired run by moving the head past it
						base_q  <= head_q;
						head_q  <= slot(head_q, idx_q);
						count_q <= count_q - idx_q;
						state_q <= S_HEAD_RD;
					end else begin
						state_q <= S_SCAN_CK;
					end
				end
				S_SCAN_CK: begin
					if (alu_carry) begin
						idx_q   <= idx_q + 1'b1;
						nfire_q <= nfire_q + 1'b1;
						state_q <= S_SCAN_RD;
					end else begin
						base_q  <= head_q;
						head_q  <= slot(head_q, idx_q);
						count_q <= count_q - idx_q;
						state_q <= S_HEAD_RD;
					end
				end
				S_HEAD_RD: state_q <= S_HEAD_WT;
				S_HEAD_WT: state_q <= (nfire_q == '0) ? S_EM_ONE : S_EM_RD;
				S_EM_ONE: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				S_EM_RD: state_q <= S_EM_LD;
				S_EM_LD: begin
					if (slot_free) begin
						k_q     <= k_q + 1'b1;
						state_q <= em_last ? S_IDLE : S_EM_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command word, local time and deadline key
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			mode_q <= cmd.mode;
			id_q   <= cmd.timer_id;
			dur_q  <= TW'(cmd.duration);
			now_q  <= TW'(cmd.now);
		end
		if (state_q == S_LT)
			key_q <= paused_q ? pause_time_q : alu_sum;
		else if (state_q == S_DL)
			key_q <= alu_sum;
		if (state_q == S_HEAD_WT)
			head_dl_q <= st_rdl;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EM_ONE || state_q == S_EM_LD) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EM_ONE || state_q == S_EM_LD) && slot_free) begin
			out_fired_q   <= (state_q == S_EM_LD);
			out_id_q      <= (state_q == S_EM_LD) ? st_rid : '0;
			out_status_q  <= status_q;
			out_pending_q <= (count_q != '0);
			out_nd_q      <= (count_q != '0) ? NW'(head_dl_q) : '0;
			out_paused_q  <= paused_q;
			out_last_q    <= (state_q == S_EM_ONE) || em_last;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.fired         = out_fired_q;
	assign res.fired_id      = out_id_q;
	assign res.status        = out_status_q;
	assign res.pending       = out_pending_q;
	assign res.next_deadline = out_nd_q;
	assign res.paused        = out_paused_q;
	assign res.last          = out_last_q;

	// the queue never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TIMERS))
		else $error("timer count above capacity");

	// one command at a time: no word taken right after another
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> !cmd.ready)
		else $error("command taken while busy");

	// an expiry is never reported with the clock stopped
	a_fire_running: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.fired) |-> !res.paused)
		else $error("timer fired while paused");

	// an empty queue reports a zero head deadline
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.pending) |-> (res.next_deadline == '0))
		else $error("head deadline on empty queue");

endmodule
